@@ design/pcu_pkg.sv @@
// ----------------------------------------------------------------------------
// pcu_pkg: shared types and constants for the periodic chain unwrapper
// Field widths, register codes, state encoding, the divider request and
// response structs, and the atom selection function.
// ----------------------------------------------------------------------------
package pcu_pkg;

	// Fixed field widths.
	localparam int COORD_W    = 32;
	localparam int CELL_W     = 31;
	localparam int CHAIN_W    = 8;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_AXES   = 3;
	localparam int AXIS_W     = 2;

	// Coordinates are Q16.16; the default box is 100 angstrom on each side.
	localparam int COORD_FRAC_BITS = 16;
	localparam logic [CELL_W-1:0] CELL_RESET = CELL_W'(100 << COORD_FRAC_BITS);

	// Image count is at most 2^32, so it needs one bit over a coordinate.
	localparam int K_W = COORD_W + 1;

	// Divider: numerator 2*|diff| + cell, denominator 2*cell.
	localparam int DIV_NUM_W = COORD_W + 3;
	localparam int DIV_DEN_W = CELL_W + 1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CELL_X = 2'd0,
		CFG_CELL_Y = 2'd1,
		CFG_CELL_Z = 2'd2,
		CFG_SELECT = 2'd3
	} cfg_idx_t;

	// Selection modes; codes above SEL_OTHER behave as SEL_OTHER.
	typedef enum logic [MODE_W-1:0] {
		SEL_ALL   = 3'd0,
		SEL_CA    = 3'd1,
		SEL_MAIN  = 3'd2,
		SEL_HEAVY = 3'd3,
		SEL_OTHER = 3'd4
	} sel_mode_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LOAD,
		ST_DIV,
		ST_MUL,
		ST_ADJ,
		ST_FIN
	} state_t;

	// Request into the shared divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	// Response from the shared divider.
	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

	// Decide whether an atom passes the configured selection.
	function automatic logic keep_atom(
		input logic [MODE_W-1:0] mode,
		input logic              ca,
		input logic              bb,
		input logic              hyd,
		input logic              solv
	);
		logic keep;
		keep = 1'b1;
		if (mode == SEL_ALL) begin
			keep = 1'b1;
		end else if (solv) begin
			keep = 1'b0;
		end else begin
			case (mode)
				SEL_CA:    keep = ca;
				SEL_MAIN:  keep = bb;
				SEL_HEAVY: keep = !hyd;
				default:   keep = 1'b1;
			endcase
		end
		return keep;
	endfunction

endpackage

@@ design/pcu_div.sv @@
// ----------------------------------------------------------------------------
// pcu_div: bit-serial restoring divider
// Produces one quotient bit per cycle, most significant first. The
// numerator register shifts left and collects the quotient bits as it goes.
// ----------------------------------------------------------------------------
module pcu_div
	import pcu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W+1:0] trial;
	logic                 borrow;

	// One trial subtraction of the denominator from the shifted remainder.
	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
		trial  = {1'b0, rem_sh} - {2'b00, den_q};
		borrow = trial[DIV_DEN_W+1];
	end

	// Control: iteration count, busy and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				cnt_q  <= CNT_W'(DIV_NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and numerator/quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= borrow ? rem_sh[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], !borrow};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

@@ design/periodic_chain_unwrap.sv @@
// ----------------------------------------------------------------------------
// periodic_chain_unwrap: minimum-image unwrap of atoms along a chain
// A dropped atom gives no beat and the next atom is taken on the next cycle;
// a kept atom that is not shifted goes through the finish state into the
// output register. A shifted atom passes, per axis, the prep, load, divide,
// multiply and adjust states (35-step serial division by twice the cell
// length), or prep, load and adjust on an axis whose cell length is zero.
// No new atom is taken until the result is issued into the output register.
// Reset clears the reference atom and restores the default 100 angstrom box.
// ----------------------------------------------------------------------------
module periodic_chain_unwrap
	import pcu_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,

	// Configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,

	// Input atom channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_W-1:0]    pos_x,
	input  logic signed [COORD_W-1:0]    pos_y,
	input  logic signed [COORD_W-1:0]    pos_z,
	input  logic [CHAIN_W-1:0]           chain_code,
	input  logic                         is_alpha_carbon,
	input  logic                         is_backbone,
	input  logic                         is_hydrogen,
	input  logic                         is_solvent_or_ion,
	input  logic                         frame_start,

	// Output atom channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_W-1:0]    out_x,
	output logic signed [COORD_W-1:0]    out_y,
	output logic signed [COORD_W-1:0]    out_z,
	output logic                         was_moved
);

	state_t state_q, state_d;

	// Configuration registers
	logic [CELL_W-1:0]  cell_q [NUM_AXES];
	logic [MODE_W-1:0]  mode_q;

	// Reference state
	logic [COORD_W-1:0] ref_q [NUM_AXES];
	logic [CHAIN_W-1:0] prev_chain_q;
	logic               have_ref_q;

	// Working registers
	logic [COORD_W-1:0] pos_q [NUM_AXES];
	logic [COORD_W-1:0] res_q [NUM_AXES];
	logic [COORD_W:0]   diff_q;
	logic [COORD_W-1:0] prod_q;
	logic               moved_q;
	logic [AXIS_W-1:0]  ax_q;

	// Output register
	logic               out_valid_q;
	logic [COORD_W-1:0] out_pos_q [NUM_AXES];
	logic               out_moved_q;

	// Combinational signals
	logic                   in_beat;
	logic                   cfg_beat;
	logic                   keep_now;
	logic                   unwrap_now;
	logic                   out_free;
	logic                   out_load;
	logic [CELL_W-1:0]      cell_cur;
	logic [DIV_NUM_W-1:0]   cell_ext;
	logic [DIV_NUM_W-1:0]   diff2;
	logic [K_W-1:0]         k_cur;
	logic [2*COORD_W-1:0]   prod_full;
	logic [COORD_W-1:0]     adj_res;

	div_req_t div_req;
	div_rsp_t div_rsp;

	pcu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Handshakes and per-atom decisions
	assign cfg_ready = 1'b1;
	assign cfg_beat  = cfg_valid && cfg_ready;
	assign in_beat   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		keep_now = keep_atom(mode_q, is_alpha_carbon, is_backbone, is_hydrogen,
			is_solvent_or_ion);
		unwrap_now = have_ref_q && !frame_start && !is_solvent_or_ion &&
			(chain_code == prev_chain_q);
	end

	// Per-axis arithmetic around the shared divider.
	always_comb begin
		cell_cur  = cell_q[ax_q];
		cell_ext  = DIV_NUM_W'(cell_cur);
		diff2     = {diff_q[COORD_W], diff_q, 1'b0};
		k_cur     = div_rsp.quot[K_W-1:0];
		prod_full = 64'(k_cur[COORD_W-1:0]) * 64'(cell_cur);
		adj_res   = diff_q[COORD_W] ? (pos_q[ax_q] + prod_q) : (pos_q[ax_q] - prod_q);
	end

	// Next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat && keep_now) begin
					state_d = unwrap_now ? ST_PREP : ST_FIN;
				end
			end
			ST_PREP: state_d = ST_LOAD;
			ST_LOAD: state_d = (cell_cur == '0) ? ST_ADJ : ST_DIV;
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_ADJ;
			ST_ADJ: state_d = (ax_q == AXIS_W'(NUM_AXES - 1)) ? ST_FIN : ST_PREP;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		out_load      = (state_q == ST_FIN) && out_free;
		div_req.start = (state_q == ST_LOAD) && (cell_cur != '0);
		// Round half away: (2*|diff| + cell) / (2*cell).
		div_req.num   = diff_q[COORD_W] ? (cell_ext - diff2) : (cell_ext + diff2);
		div_req.den   = {cell_cur, 1'b0};
	end

	// Control state, configuration and reference registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ax_q         <= '0;
			out_valid_q  <= 1'b0;
			mode_q       <= SEL_ALL;
			prev_chain_q <= '0;
			have_ref_q   <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				cell_q[i] <= CELL_RESET;
				ref_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_beat) begin
				case (cfg_index)
					CFG_CELL_X: cell_q[0] <= cfg_data[CELL_W-1:0];
					CFG_CELL_Y: cell_q[1] <= cfg_data[CELL_W-1:0];
					CFG_CELL_Z: cell_q[2] <= cfg_data[CELL_W-1:0];
					CFG_SELECT: mode_q    <= cfg_data[MODE_W-1:0];
					default:    ;
				endcase
			end

			// Every atom updates the chain; a frame start drops the reference.
			if (in_beat) begin
				prev_chain_q <= chain_code;
				ax_q         <= '0;
				if (frame_start) begin
					have_ref_q <= 1'b0;
				end
			end

			// Step to the next axis; the last axis leaves the counter in place.
			if ((state_q == ST_ADJ) && (ax_q != AXIS_W'(NUM_AXES - 1))) begin
				ax_q <= ax_q + 1'b1;
			end

			// A kept atom becomes the reference once its result is issued.
			if (out_load) begin
				have_ref_q <= 1'b1;
				for (int i = 0; i < NUM_AXES; i++) begin
					ref_q[i] <= res_q[i];
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			res_q[0] <= pos_x;
			res_q[1] <= pos_y;
			res_q[2] <= pos_z;
			moved_q  <= 1'b0;
		end

		case (state_q)
			ST_PREP: begin
				diff_q <= {pos_q[ax_q][COORD_W-1], pos_q[ax_q]} -
					{ref_q[ax_q][COORD_W-1], ref_q[ax_q]};
			end
			ST_LOAD: begin
				if (cell_cur == '0) begin
					prod_q <= '0;
				end
			end
			ST_MUL: begin
				prod_q  <= prod_full[COORD_W-1:0];
				moved_q <= moved_q || (k_cur != '0);
			end
			ST_ADJ: begin
				res_q[ax_q] <= adj_res;
			end
			default: ;
		endcase

		if (out_load) begin
			out_moved_q <= moved_q;
			for (int i = 0; i < NUM_AXES; i++) begin
				out_pos_q[i] <= res_q[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_pos_q[0];
	assign out_y     = out_pos_q[1];
	assign out_z     = out_pos_q[2];
	assign was_moved = out_moved_q;

	// The divider is never restarted while it is still iterating.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// The axis counter never runs past the last axis.
	assert property (@(posedge clk) disable iff (!arst_n)
		ax_q != AXIS_W'(NUM_AXES))
		else $error("axis counter out of range");

	// A new result beat only appears after the finish state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result presented outside the finish state");

	// In the divide state the input is stalled and the divider is busy or just done.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> in_stall && div_rsp.busy || div_rsp.done)
		else $error("divide state without an active division");

endmodule
